[design/assert_macros.svh]
// Assertion macros used by the checker file of the frame receiver.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SEFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SEFR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sefr_pkg.sv]
// Shared types and codes of the STX/ETX frame receiver.
// No dependencies; imported by the control, top level and checker.
package sefr_pkg;

    // receive phases
    localparam logic [1:0] PH_WAIT_ACK   = 2'd0;
    localparam logic [1:0] PH_WAIT_START = 2'd1;
    localparam logic [1:0] PH_HEADER     = 2'd2;
    localparam logic [1:0] PH_BODY       = 2'd3;

    // status codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_GOOD     = 3'd1;
    localparam logic [2:0] EV_BAD_END  = 3'd2;
    localparam logic [2:0] EV_BAD_BCC  = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;

    // function select
    localparam logic FN_RECEIVE = 1'b0;
    localparam logic FN_READ    = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_ACK   = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] ACK_RESET   = 8'd6;
    localparam logic [7:0] START_RESET = 8'd2;
    localparam logic [7:0] END_RESET   = 8'd3;

    // header geometry: the length byte sits at this index
    localparam logic [8:0] LEN_INDEX = 9'd3;
    // body count is length plus this trailer size (end byte and check byte)
    localparam logic [7:0] TRAILER_BYTES = 8'd2;

    // status of one step, as reported with each result beat
    typedef struct packed {
        logic [2:0] event_code;
        logic [8:0] frame_length;
        logic [1:0] phase;
    } t_step;

endpackage

[design/sefr_in_if.sv]
// Input channel of the frame receiver: valid/ready handshake plus request payload.
// No dependencies.
interface sefr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, func, rx_byte, read_index, input ready);
    modport sink   (input valid, func, rx_byte, read_index, output ready);
endinterface

[design/sefr_out_if.sv]
// Result channel of the frame receiver: valid/ready handshake plus status payload.
// No dependencies.
interface sefr_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [8:0] frame_length;
    logic [7:0] read_data;
    logic [1:0] phase;

    modport source (output valid, event_code, frame_length, read_data, phase, input ready);
    modport sink   (input valid, event_code, frame_length, read_data, phase, output ready);
endinterface

[design/sefr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sefr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/sefr_ctrl.sv]
// Receive sequencer of the frame receiver: phase, counts, running XOR, config registers.
// Depends on sefr_pkg; drives the store write port and the per-beat status.
module sefr_ctrl
    import sefr_pkg::*;
#(
    parameter int STORE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_fire,
    input  logic [7:0] i_rx_byte,
    output logic       o_wr_en,
    output logic [8:0] o_wr_count,
    output t_step      o_step
);
    logic [7:0] r_ack_code, r_start_code, r_end_code;
    logic [1:0] r_phase, n_phase;
    logic [8:0] r_byte_count, n_byte_count;
    logic [7:0] r_remaining, n_remaining;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_last, n_last;
    logic [2:0] w_event;
    logic       w_wr_en;
    logic       w_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_code   <= ACK_RESET;
            r_start_code <= START_RESET;
            r_end_code   <= END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACK:   r_ack_code   <= i_cfg_data;
                CFG_START: r_start_code <= i_cfg_data;
                CFG_END:   r_end_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // store is full once the count reaches the depth
    assign w_full = (32'(r_byte_count) >= STORE_DEPTH);

    // next-state logic for one received byte
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_remaining  = r_remaining;
        n_xor        = r_xor;
        n_last       = r_last;
        w_event      = EV_NONE;
        w_wr_en      = 1'b0;
        if (i_fire) begin
            if (r_phase == PH_WAIT_ACK) begin
                if (i_rx_byte == r_ack_code) begin
                    n_byte_count = '0;
                    n_xor        = '0;
                    n_phase      = PH_WAIT_START;
                end
            end else if (w_full) begin
                // drop the frame
                w_event = EV_OVERFLOW;
                n_phase = PH_WAIT_ACK;
            end else begin
                w_wr_en      = 1'b1;
                n_byte_count = 9'(r_byte_count + 9'd1);
                n_xor        = r_xor ^ i_rx_byte;
                n_last       = i_rx_byte;
                unique case (r_phase)
                    PH_WAIT_START: begin
                        n_phase = (i_rx_byte == r_start_code) ? PH_HEADER : PH_WAIT_ACK;
                    end
                    PH_HEADER: begin
                        if (r_byte_count == LEN_INDEX) begin
                            n_remaining = 8'(i_rx_byte + TRAILER_BYTES);
                            n_phase     = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_remaining = 8'(r_remaining - 8'd1);
                        if (n_remaining == 8'd0) begin
                            // previous stored byte must be the end byte
                            if (r_last != r_end_code) begin
                                w_event = EV_BAD_END;
                            end else if (i_rx_byte != r_xor) begin
                                w_event = EV_BAD_BCC;
                            end else begin
                                w_event = EV_GOOD;
                            end
                            n_phase = PH_WAIT_ACK;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_ACK;
            r_byte_count <= '0;
            r_remaining  <= '0;
            r_xor        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_remaining  <= n_remaining;
            r_xor        <= n_xor;
        end
    end

    // last stored byte, payload only
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
    end

    assign o_wr_en             = w_wr_en;
    assign o_wr_count          = r_byte_count;
    assign o_step.event_code   = w_event;
    assign o_step.frame_length = n_byte_count;
    assign o_step.phase        = n_phase;
endmodule

[design/ack_stx_etx_frame_receiver_unit.sv]
// Acknowledged STX/ETX frame receiver with XOR block check and a frame store.
// A result beat passes from stage 1, where the store read is registered, to the output
// register. Throughput: one beat per cycle while the output is not stalled;
// the sequencer updates its state once per accepted byte.
// Reset clears phase, counts, XOR and pipeline valids and restores the config defaults;
// the frame store has no reset and needs no clearing pass.
module ack_stx_etx_frame_receiver_unit
    import sefr_pkg::*;
#(
    parameter int STORE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    sefr_in_if.sink    i_in,
    sefr_out_if.source o_out
);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    logic              w_accept;
    logic              w_fire;
    logic              w_read;
    logic              w_s1_adv;
    logic              w_wr_en;
    logic [8:0]        w_wr_count;
    logic [31:0]       w_wr_wide;
    logic [31:0]       w_rd_wide;
    logic              w_rd_in_range;
    logic [7:0]        w_rdata;
    t_step             w_step;

    logic              r_s1_valid;
    t_step             r_s1_step;
    logic              r_s1_rd;
    logic              r_out_valid;
    t_step             r_out_step;
    logic [7:0]        r_out_data;

    // handshake
    assign w_s1_adv   = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_fire     = w_accept && (i_in.func == FN_RECEIVE);
    assign w_read     = w_accept && (i_in.func == FN_READ);

    // store addressing
    assign w_wr_wide     = 32'(w_wr_count);
    assign w_rd_wide     = 32'(i_in.read_index);
    assign w_rd_in_range = (w_rd_wide < STORE_DEPTH);

    sefr_ctrl #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_rx_byte   (i_in.rx_byte),
        .o_wr_en     (w_wr_en),
        .o_wr_count  (w_wr_count),
        .o_step      (w_step)
    );

    sefr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_wide[ADDR_W-1:0]),
        .i_wdata (i_in.rx_byte),
        .i_re    (w_read && w_rd_in_range),
        .i_raddr (w_rd_wide[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // stage 1 valid: hold while the output register is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_step <= w_step;
            r_s1_rd   <= w_read && w_rd_in_range;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output register payload; store data lands here
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_valid) begin
            r_out_step <= r_s1_step;
            r_out_data <= r_s1_rd ? w_rdata : 8'd0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_code   = r_out_step.event_code;
    assign o_out.frame_length = r_out_step.frame_length;
    assign o_out.phase        = r_out_step.phase;
    assign o_out.read_data    = r_out_data;
endmodule

[design/sefr_checker.sv]
// Port-level checks of the frame receiver and the bind that attaches them.
// Depends on sefr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sefr_checker
    import sefr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_event_code,
    input logic [8:0] i_frame_length,
    input logic [1:0] i_phase
);
    // a stalled result beat stays offered
    `SEFR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")

    // status codes stay in range
    `SEFR_ASSERT_IMP(a_event_range, i_clk, i_rst_n, i_out_valid, i_event_code <= EV_OVERFLOW, "status code out of range")

    // every reported outcome ends the frame
    `SEFR_ASSERT_IMP(a_event_phase, i_clk, i_rst_n, i_out_valid && (i_event_code != EV_NONE), i_phase == PH_WAIT_ACK, "outcome reported without return to ack wait")

    // a completed frame holds at least the header and one body byte;
    // a length byte of 255 asks for a single body byte and doubles as the end byte
    `SEFR_ASSERT_IMP(a_good_len, i_clk, i_rst_n, i_out_valid && (i_event_code == EV_GOOD), i_frame_length >= 9'd5, "good frame shorter than minimum")
endmodule

bind ack_stx_etx_frame_receiver_unit sefr_checker u_sefr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_event_code   (o_out.event_code),
    .i_frame_length (o_out.frame_length),
    .i_phase        (o_out.phase)
);
